// File: rtl/core/sketch_bit_matrix_union_defines.svh
// Assertion macros for the bit-matrix union core.
// Used by sketch_bit_matrix_union.sv; no other dependencies.
`ifndef SKETCH_BIT_MATRIX_UNION_DEFINES_SVH
`define SKETCH_BIT_MATRIX_UNION_DEFINES_SVH

// same-cycle implication
`define SBMU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SBMU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/sbmu_pkg.sv
// Shared constants and types of the bit-matrix union core.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package sbmu_pkg;

  localparam int MAX_LG_K_DEF = 12;
  localparam int LG_K_RESET   = 12;
  localparam int WOFF_MAX     = 56;

  localparam int ACTION_W = 3;
  localparam int SROW_W   = 26;
  localparam int RC_W     = 32;
  localparam int BYTE_W   = 8;
  localparam int OFF_W    = 6;
  localparam int WORD_W   = 64;
  localparam int CPN_W    = 18;
  localparam int BITS_W   = 7;
  localparam int LGK_W    = 4;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR     = 3'd0,
    ACT_OR_COUPON = 3'd1,
    ACT_OR_WINDOW = 3'd2,
    ACT_OR_ROW    = 3'd3,
    ACT_READ      = 3'd4
  } action_t;

  typedef enum logic [0:0] {
    REG_LG_K = 1'b0,
    REG_WOFF = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MODIFY,
    ST_SCAN,
    ST_FIRST,
    ST_EMIT
  } state_t;

endpackage

// File: rtl/core/sbmu_in_if.sv
// Input channel of the bit-matrix union core: valid/ready plus item fields.
// Depends on sbmu_pkg for field widths.
`timescale 1ns / 1ps

interface sbmu_in_if;
  logic                              valid;
  logic                              ready;
  logic [sbmu_pkg::ACTION_W-1:0]     action;
  logic [sbmu_pkg::SROW_W-1:0]       source_row;
  logic [sbmu_pkg::RC_W-1:0]         row_col;
  logic [sbmu_pkg::BYTE_W-1:0]       window_in;
  logic [sbmu_pkg::OFF_W-1:0]        source_offset;
  logic [sbmu_pkg::WORD_W-1:0]       row_word;

  modport source (output valid, action, source_row, row_col, window_in, source_offset,
                  row_word, input ready);
  modport sink   (input valid, action, source_row, row_col, window_in, source_offset,
                  row_word, output ready);
endinterface

// File: rtl/core/sbmu_out_if.sv
// Result channel of the bit-matrix union core: valid/ready plus readout fields.
// Depends on sbmu_pkg for field widths.
`timescale 1ns / 1ps

interface sbmu_out_if;
  logic                              valid;
  logic                              ready;
  logic [sbmu_pkg::BYTE_W-1:0]       window_out;
  logic [sbmu_pkg::CPN_W-1:0]        coupon;
  logic                              coupon_valid;
  logic [sbmu_pkg::BITS_W-1:0]       row_bits;
  logic [sbmu_pkg::OFF_W-1:0]        first_column;
  logic                              last;

  modport source (output valid, window_out, coupon, coupon_valid, row_bits, first_column,
                  last, input ready);
  modport sink   (input valid, window_out, coupon, coupon_valid, row_bits, first_column,
                  last, output ready);
endinterface

// File: rtl/core/sketch_bit_matrix_union.sv
// Bit-matrix union core: row memory, OR updates, row readout with surprise coupons.
// Depends on sbmu_pkg, sbmu_in_if, sbmu_out_if and sketch_bit_matrix_union_defines.svh.
`timescale 1ns / 1ps

// The matrix lives in one 2^MAX_LG_K x 64 synchronous RAM. After reset and after a
// clear item the core sweeps the RAM, one row per cycle, and holds req.ready low
// meanwhile; APB writes are taken at any time. Each OR item is a RAM read on the
// accepting edge, then the write-back of the merged row. A read item passes through
// a RAM read, the surprise scan and popcount, and the first-column search, then
// emits one beat per surprising bit, at least one beat and at most 56, each beat
// paced by rsp.ready. Results sit in an output register, so the next item is taken
// while the final beat of a readout waits.
module sketch_bit_matrix_union #(
  parameter int MAX_LG_K = sbmu_pkg::MAX_LG_K_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sbmu_pkg::APB_AW-1:0]     paddr,
  input  logic [sbmu_pkg::APB_DW-1:0]     pwdata,
  output logic [sbmu_pkg::APB_DW-1:0]     prdata,
  output logic                            pready,
  sbmu_in_if.sink                         req,
  sbmu_out_if.source                      rsp
);
  import sbmu_pkg::*;
  `include "sketch_bit_matrix_union_defines.svh"

  localparam int AW   = MAX_LG_K;
  localparam int ROWS = 1 << MAX_LG_K;

  function automatic logic [OFF_W-1:0] onehot_index(input logic [WORD_W-1:0] v);
    logic [OFF_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (v[i]) idx = idx | OFF_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [BITS_W-1:0] popcount(input logic [WORD_W-1:0] v);
    logic [3:0]        cnt [8];
    logic [BITS_W-1:0] sum;
    sum = '0;
    for (int b = 0; b < 8; b++) begin
      cnt[b] = '0;
      for (int i = 0; i < 8; i++) cnt[b] = cnt[b] + 4'(v[8*b+i]);
    end
    for (int b = 0; b < 8; b++) sum = sum + BITS_W'(cnt[b]);
    return sum;
  endfunction

  // configuration
  logic [LGK_W-1:0] lg_k;
  logic [OFF_W-1:0] woff;
  logic             cfg_we;
  logic [LGK_W-1:0] lgk_wr;
  logic [OFF_W-1:0] woff_wr;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    lgk_wr = pwdata[LGK_W-1:0];
    if (lgk_wr < LGK_W'(4)) lgk_wr = LGK_W'(4);
    if (lgk_wr > MAX_LG_K) lgk_wr = LGK_W'(MAX_LG_K);
    woff_wr = pwdata[OFF_W-1:0];
    if (woff_wr > OFF_W'(WOFF_MAX)) woff_wr = OFF_W'(WOFF_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lg_k <= (LG_K_RESET > MAX_LG_K) ? LGK_W'(MAX_LG_K) : LGK_W'(LG_K_RESET);
      woff <= '0;
    end else if (cfg_we) begin
      if (paddr[2] == REG_LG_K) lg_k <= lgk_wr;
      else woff <= woff_wr;
    end
  end

  assign prdata = (paddr[2] == REG_WOFF) ? APB_DW'(woff) : APB_DW'(lg_k);

  // row mask from lg_k
  logic [AW-1:0] row_mask;
  always_comb begin
    for (int i = 0; i < AW; i++) row_mask[i] = (i < lg_k);
  end

  // control state
  state_t            state, state_next;
  logic [AW-1:0]     clr_cnt;
  logic              accept;
  logic              out_load;
  logic              o_valid;

  // item registers
  logic [AW-1:0]     cur_row;
  logic [WORD_W-1:0] operand;
  logic [WORD_W-1:0] pat;
  logic [WORD_W-1:0] union_r;
  logic [BITS_W-1:0] bits;
  logic [BYTE_W-1:0] wbyte;
  logic [OFF_W-1:0]  fc;

  // memory
  logic [WORD_W-1:0] mem [ROWS];
  logic [WORD_W-1:0] rd_data;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata;

  logic [AW-1:0]     in_row;
  logic [WORD_W-1:0] in_operand;
  logic [WORD_W-1:0] low_bit, pat_after;
  logic [OFF_W-1:0]  low_col;
  logic              last_next;

  assign accept   = req.valid && req.ready;
  assign out_load = (state == ST_EMIT) && (!o_valid || rsp.ready);

  assign low_bit   = pat & (~pat + 64'd1);
  assign pat_after = pat & (pat - 64'd1);
  assign low_col   = onehot_index(low_bit);
  assign last_next = (pat_after == '0);

  always_comb begin
    if (req.action == ACT_OR_COUPON) in_row = req.row_col[6 +: AW] & row_mask;
    else in_row = req.source_row[AW-1:0] & row_mask;
    case (req.action)
      ACT_OR_COUPON: begin
        if (req.row_col == '1) in_operand = '0;
        else in_operand = 64'd1 << req.row_col[OFF_W-1:0];
      end
      ACT_OR_WINDOW: in_operand = WORD_W'(req.window_in) << req.source_offset;
      ACT_OR_ROW:    in_operand = req.row_word;
      default:       in_operand = '0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (clr_cnt == '1) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          case (req.action)
            ACT_CLEAR:     state_next = ST_CLEAR;
            ACT_OR_COUPON,
            ACT_OR_WINDOW,
            ACT_OR_ROW:    state_next = ST_MODIFY;
            ACT_READ:      state_next = ST_SCAN;
            default:       state_next = ST_IDLE;
          endcase
        end
      end
      ST_MODIFY: state_next = ST_IDLE;
      ST_SCAN:   state_next = ST_FIRST;
      ST_FIRST:  state_next = ST_EMIT;
      ST_EMIT:   if (out_load && (pat == '0 || last_next)) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req.ready = (state == ST_IDLE);
    mem_re    = accept;
    mem_raddr = in_row;
    mem_we    = 1'b0;
    mem_waddr = cur_row;
    mem_wdata = rd_data | operand;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      ST_MODIFY: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      union_r <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (accept && req.action == ACT_CLEAR) begin
        clr_cnt <= '0;
        union_r <= '0;
      end
      if (state == ST_SCAN) begin
        union_r <= union_r |
                   ((rd_data & ~(64'hff << woff)) ^ ((64'd1 << woff) - 64'd1));
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_row <= in_row;
      operand <= in_operand;
    end
    case (state)
      ST_SCAN: begin
        pat   <= (rd_data & ~(64'hff << woff)) ^ ((64'd1 << woff) - 64'd1);
        bits  <= popcount(rd_data);
        wbyte <= BYTE_W'(rd_data >> woff);
      end
      ST_FIRST: begin
        if (union_r == '0) fc <= woff;
        else if (onehot_index(union_r & (~union_r + 64'd1)) > woff) fc <= woff;
        else fc <= onehot_index(union_r & (~union_r + 64'd1));
      end
      ST_EMIT: if (out_load && pat != '0) pat <= pat_after;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_load) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.window_out   <= wbyte;
      rsp.row_bits     <= bits;
      rsp.first_column <= fc;
      if (pat == '0) begin
        rsp.coupon       <= '0;
        rsp.coupon_valid <= 1'b0;
        rsp.last         <= 1'b1;
      end else begin
        rsp.coupon       <= CPN_W'({cur_row, low_col});
        rsp.coupon_valid <= 1'b1;
        rsp.last         <= last_next;
      end
    end
  end

  assign rsp.valid = o_valid;

  `SBMU_ASSERT_NEXT(a_or_goes_modify, clk, rst,
    accept && (req.action == ACT_OR_ROW || req.action == ACT_OR_WINDOW),
    state == ST_MODIFY, "OR item did not reach write-back")
  `SBMU_ASSERT_NEXT(a_clear_holds, clk, rst,
    state == ST_CLEAR && clr_cnt != '1, state == ST_CLEAR, "clearing pass cut short")
  `SBMU_ASSERT_NEXT(a_pat_stalls, clk, rst,
    state == ST_EMIT && o_valid && !rsp.ready, $stable(pat), "pattern moved on a stall")
  `SBMU_ASSERT_NOW(a_no_write_in_readout, clk, rst,
    state == ST_SCAN || state == ST_FIRST || state == ST_EMIT, !mem_we,
    "row memory written during readout")

endmodule
